// File: hdl/lscr_pkg.sv
// shared types and constants for the line scan camera readout
package lscr_pkg;

    localparam int MODE_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int PIX_W    = 12;
    localparam int CAP_W    = 16;

    // adc conversion keeps its top twelve bits
    localparam int SAMPLE_SHIFT = 4;

    localparam logic [CAP_W-1:0] CAP_MAX          = '1;
    localparam logic [CAP_W-1:0] INTERVAL_DEFAULT = 16'd2667;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 3'd0,
        MODE_SAMPLE = 3'd1,
        MODE_START  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_ACK    = 3'd4
    } t_mode;

    // sensor pin and status levels after one item
    typedef struct packed {
        logic clock;
        logic si;
        logic active;
        logic done;
        logic report_due;
    } t_status;

endpackage

// File: hdl/lscr_ctrl.sv
// readout sequencer: pixel counter, sensor clock and si, capture counting
module lscr_ctrl #(
    parameter int LINE_PIXELS = 128,
    parameter int AW          = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [lscr_pkg::MODE_W-1:0]    i_mode,
    input  logic [lscr_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [lscr_pkg::CAP_W-1:0]     i_interval,
    output lscr_pkg::t_status              o_status,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [lscr_pkg::PIX_W-1:0]     o_wr_data
);
    import lscr_pkg::*;

    localparam int CW = $clog2(2 * LINE_PIXELS + 1) + 1;
    localparam logic signed [CW-1:0] CNT_START  = CW'(-2);
    localparam logic signed [CW-1:0] CNT_SI_ON  = CW'(-1);
    localparam logic signed [CW-1:0] CNT_SI_OFF = CW'(1);
    localparam logic signed [CW-1:0] CNT_PIX    = CW'(2);
    localparam logic signed [CW-1:0] CNT_END    = CW'(2 * LINE_PIXELS);

    logic signed [CW-1:0] r_cnt, n_cnt;
    logic                 r_clk, n_clk;
    logic                 r_si, n_si;
    logic                 r_armed, n_armed;
    logic [PIX_W-1:0]     r_sample, n_sample;
    logic [CAP_W-1:0]     r_cap, n_cap;
    logic                 done;
    logic                 wr_en;

    always_comb begin
        n_cnt    = r_cnt;
        n_clk    = r_clk;
        n_si     = r_si;
        n_armed  = r_armed;
        n_sample = r_sample;
        n_cap    = r_cap;
        done     = 1'b0;
        wr_en    = 1'b0;
        case (t_mode'(i_mode))
            MODE_TICK: begin
                if (r_armed) begin
                    n_clk = ~r_clk;
                    if (r_cnt >= CNT_PIX && r_cnt < CNT_END) begin
                        // pixels land on falling edges of the sensor clock
                        wr_en = ~n_clk;
                        n_cnt = r_cnt + CW'(1);
                    end else if (r_cnt < CNT_PIX) begin
                        if (r_cnt == CNT_SI_ON) begin
                            n_si = 1'b1;
                        end else if (r_cnt == CNT_SI_OFF) begin
                            n_si  = 1'b0;
                            wr_en = 1'b1;
                        end
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_clk   = 1'b0;
                        n_cnt   = CNT_START;
                        n_armed = 1'b0;
                        done    = 1'b1;
                    end
                end
            end
            MODE_SAMPLE: begin
                n_sample = i_sample[SAMPLE_SHIFT +: PIX_W];
            end
            MODE_START: begin
                if (r_cap != CAP_MAX) begin
                    n_cap = r_cap + CAP_W'(1);
                end
                n_armed = 1'b1;
            end
            MODE_ACK: begin
                n_cap = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CNT_START;
            r_clk    <= 1'b0;
            r_si     <= 1'b1;
            r_armed  <= 1'b0;
            r_sample <= '0;
            r_cap    <= '0;
        end else if (i_step) begin
            r_cnt    <= n_cnt;
            r_clk    <= n_clk;
            r_si     <= n_si;
            r_armed  <= n_armed;
            r_sample <= n_sample;
            r_cap    <= n_cap;
        end
    end

    assign o_status.clock      = n_clk;
    assign o_status.si         = n_si;
    assign o_status.active     = n_armed;
    assign o_status.done       = done;
    assign o_status.report_due = (n_cap >= i_interval);

    // pixel index is count / 2, which also gives pixel 0 at count 1
    assign o_wr_en   = i_step && wr_en;
    assign o_wr_addr = r_cnt[AW:1];
    assign o_wr_data = r_sample;

    a_idle_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_cnt == CNT_START) && !r_clk)
        else $error("disarmed sequencer not parked");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= CNT_START) && (r_cnt <= CNT_END))
        else $error("pixel counter out of range");

endmodule

// File: hdl/lscr_line_mem.sv
// line store with fill count and registered read port
module lscr_line_mem #(
    parameter int LINE_PIXELS = 128,
    parameter int AW          = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [lscr_pkg::PIX_W-1:0]    i_wr_data,
    input  logic                          i_rd_en,
    input  logic [lscr_pkg::IDX_W-1:0]    i_rd_index,
    output logic [lscr_pkg::PIX_W-1:0]    o_rd_data
);
    import lscr_pkg::*;

    localparam int FW = $clog2(LINE_PIXELS + 1);
    localparam int IW = (IDX_W > FW) ? IDX_W : FW;

    logic [PIX_W-1:0] r_mem [LINE_PIXELS];
    logic [PIX_W-1:0] r_rd_data;
    logic             r_rd_ok;
    logic [FW-1:0]    r_fill;
    logic [IW-1:0]    rd_ext;
    logic             rd_ok;

    // pixels are always written in ascending order, so nothing at or
    // above the fill count has been written yet, and reads there return zero
    assign rd_ext = IW'(i_rd_index);
    assign rd_ok  = i_rd_en && (rd_ext < IW'(r_fill));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_step && rd_ok) begin
            r_rd_data <= r_mem[rd_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en && (FW'(i_wr_addr) >= r_fill)) begin
                r_fill <= FW'(i_wr_addr) + FW'(1);
            end
            if (i_step) begin
                r_rd_ok <= rd_ok;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_PIXELS))
        else $error("fill count beyond line length");

endmodule

// File: hdl/line_scan_camera_readout_top.sv
// top level of the line scan camera readout sequencer
// Readout sequencer for a linear image sensor of LINE_PIXELS pixels. Each
// input transfer carries a mode: clock tick (toggles the sensor clock and
// steps the pixel counter while a capture is armed), adc result (keeps the
// conversion shifted right by four), integration start (arms a capture and
// counts it), read pixel (returns one stored pixel) and acknowledge (clears
// the capture count). Every input transfer yields exactly one output
// transfer with the pin levels and status after it. An item passes through
// an input register, the sequencer logic and a result register, so the
// block takes one item per cycle while the output is not stalled; the
// line store read port is clocked into the result stage with the status.
// While a finished result waits on a stalled output, the input register
// still takes one more transfer and the input then stalls until the result
// moves. The line store needs no clearing pass after reset: pixels are
// always written in ascending order, so a fill count marks the entries that
// still read as zero. The user must write report_interval via the always
// ready configuration channel only while the block is idle; not enforced.
module line_scan_camera_readout_top #(
    parameter int LINE_PIXELS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lscr_pkg::MODE_W-1:0]   i_mode,
    input  logic [lscr_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [lscr_pkg::IDX_W-1:0]    i_read_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_sensor_clock,
    output logic                          o_sensor_si,
    output logic                          o_capture_active,
    output logic                          o_line_done,
    output logic                          o_report_due,
    output logic [lscr_pkg::PIX_W-1:0]    o_pixel_data,
    // report_interval write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lscr_pkg::CAP_W-1:0]    i_cfg_data
);
    import lscr_pkg::*;

    localparam int AW = $clog2(LINE_PIXELS);

    // input register
    logic                r_in_valid;
    logic [MODE_W-1:0]   r_mode;
    logic [SAMPLE_W-1:0] r_sample;
    logic [IDX_W-1:0]    r_idx;

    // result register
    logic                r_out_valid;
    t_status             r_status;

    logic [CAP_W-1:0]    r_interval;

    logic                step;
    logic                in_xfer;
    t_status             status;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [PIX_W-1:0]    wr_data;

    // item moves from the input register into the result register when the
    // result slot is empty or its current content is being transferred out
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_interval  <= INTERVAL_DEFAULT;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode   <= i_mode;
            r_sample <= i_sample_value;
            r_idx    <= i_read_index;
        end
        if (step) begin
            r_status <= status;
        end
    end

    lscr_ctrl #(
        .LINE_PIXELS (LINE_PIXELS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_mode     (r_mode),
        .i_sample   (r_sample),
        .i_interval (r_interval),
        .o_status   (status),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // read data register doubles as the pixel field of the result register
    lscr_line_mem #(
        .LINE_PIXELS (LINE_PIXELS),
        .AW          (AW)
    ) u_line_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (r_mode == MODE_READ),
        .i_rd_index (r_idx),
        .o_rd_data  (o_pixel_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_sensor_clock   = r_status.clock;
    assign o_sensor_si      = r_status.si;
    assign o_capture_active = r_status.active;
    assign o_line_done      = r_status.done;
    assign o_report_due     = r_status.report_due;

    // the finishing tick always leaves the clock low and the capture disarmed
    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status.done) |-> (!r_status.active && !r_status.clock))
        else $error("line done with capture still armed");

    // a waiting item may only be held back by a stalled, occupied result slot
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without output back pressure");

endmodule
